### design/hed_pkg.sv
// Shared constants, types and helper functions for the HTML entity decoder.
// Depends on nothing; every other file of the decoder but hed_ram imports it.
package hed_pkg;

    // Character code width on the ports, and the range of numeric entities.
    localparam int CODE_W     = 16;
    localparam int CHAR_BITS  = 16;
    localparam int NUM_W      = CHAR_BITS + 1;

    // Entity buffer sizing.
    localparam int ENTITY_MAX = 16;
    localparam int IDX_W      = $clog2(ENTITY_MAX);
    localparam int LEN_W      = $clog2(ENTITY_MAX + 1);

    localparam logic [LEN_W-1:0] ENTITY_FULL = LEN_W'(ENTITY_MAX);

    // Largest character code a numeric entity may produce, and the
    // saturation value that marks an overflow.
    localparam logic [NUM_W-1:0] MAX_CODE  = {1'b0, {CHAR_BITS{1'b1}}};
    localparam logic [NUM_W-1:0] NUM_SAT   = {1'b1, {CHAR_BITS{1'b0}}};

    // Character codes.
    localparam logic [CODE_W-1:0] AMP_CODE   = 16'h0026;
    localparam logic [CODE_W-1:0] SEMI_CODE  = 16'h003B;
    localparam logic [CODE_W-1:0] HASH_CODE  = 16'h0023;
    localparam logic [CODE_W-1:0] SPACE_CODE = 16'h0020;
    localparam logic [CODE_W-1:0] LT_CODE    = 16'h003C;
    localparam logic [CODE_W-1:0] GT_CODE    = 16'h003E;
    localparam logic [CODE_W-1:0] DIGIT_LO   = 16'h0030;
    localparam logic [CODE_W-1:0] DIGIT_HI   = 16'h0039;
    localparam logic [CODE_W-1:0] UPPER_LO   = 16'h0041;
    localparam logic [CODE_W-1:0] UPPER_HI   = 16'h005A;

    // Named entities, lower case, padded to four characters. The padding is
    // never compared because the position is checked against the length.
    localparam int NAME_POS_W = 2;
    localparam logic [LEN_W-1:0] NBSP_LEN = LEN_W'(4);
    localparam logic [LEN_W-1:0] LT_LEN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] GT_LEN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] AMPN_LEN = LEN_W'(3);

    localparam logic [CODE_W-1:0] NAME_NBSP [4] = '{16'h006E, 16'h0062, 16'h0073, 16'h0070};
    localparam logic [CODE_W-1:0] NAME_LT   [4] = '{16'h006C, 16'h0074, 16'h0000, 16'h0000};
    localparam logic [CODE_W-1:0] NAME_GT   [4] = '{16'h0067, 16'h0074, 16'h0000, 16'h0000};
    localparam logic [CODE_W-1:0] NAME_AMP  [4] = '{16'h0061, 16'h006D, 16'h0070, 16'h0000};

    // One result beat.
    typedef struct packed {
        logic [CODE_W-1:0] out_char;
        logic              has_char;
        logic              text_done;
        logic              last_of_run;
    } result_t;

    // ASCII upper case folded to lower case; everything else unchanged.
    function automatic logic [CODE_W-1:0] lower_ascii(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] r;
        r = c;
        if (c >= UPPER_LO && c <= UPPER_HI)
        begin
            r = c + 16'h0020;
        end
        return r;
    endfunction

    // Character plus beat flags for a result that carries a character.
    function automatic result_t char_beat(input logic [CODE_W-1:0] c,
                                          input logic last, input logic done);
        result_t r;
        r.out_char    = c;
        r.has_char    = 1'b1;
        r.text_done   = done;
        r.last_of_run = last;
        return r;
    endfunction

endpackage

### design/hed_if.sv
// Valid/ready channel interfaces for the HTML entity decoder: one for the
// incoming text characters and one for the decoded result beats.
// Depends on hed_pkg for the character width.
interface hed_in_if import hed_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] char_code;
    logic              end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);

endinterface

interface hed_out_if import hed_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] out_char;
    logic              has_char;
    logic              text_done;
    logic              last_of_run;

    modport source (output valid, output out_char, output has_char, output text_done,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input has_char, input text_done,
                    input last_of_run, output ready);

endinterface

### design/hed_ram.sv
// Generic single-clock RAM: one write port and one read port with a
// registered read. Depends on nothing.
module hed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### design/html_entity_decoder.sv
// Top level of the streaming HTML character entity decoder.
// Depends on hed_pkg, the channel interfaces in hed_if and the RAM in hed_ram.
//
//   Channel    Direction  Beat carries
//   char_in    in         char_code, end_of_text
//   char_out   out        out_char, has_char, text_done, last_of_run
//
// A character that yields at most one result is taken every cycle unless
// char_out stalls or a flush runs; the result sits in the output register
// while the next character is accepted. A verbatim flush sends the '&',
// then each held character read from the buffer RAM through its one read
// port, then an optional trailing character, all through the single output
// register; input is held off during a flush. Stalls on char_out back up to
// char_in with no loss. Reset is asynchronous and active low; the buffer
// RAM needs no clearing.
module html_entity_decoder import hed_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    hed_in_if.sink           char_in,
    hed_out_if.source        char_out
);

    // Flush sequencer phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_AMP  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_TAIL = 2'd3;

    // Entity state. The characters themselves live in the buffer RAM; the
    // numeric value and the name matches are tracked as characters arrive so
    // that closing an entity never has to read the buffer back.
    logic             in_entity_reg, in_entity_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic             stopped_reg, stopped_next;
    logic             hash_reg, hash_next;
    logic             m_nbsp_reg, m_nbsp_next;
    logic             m_lt_reg, m_lt_next;
    logic             m_gt_reg, m_gt_next;
    logic             m_amp_reg, m_amp_next;

    // Flush sequencer.
    logic [1:0]        phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              tail_valid_reg, tail_valid_next;
    logic [CODE_W-1:0] tail_char_reg, tail_char_next;
    logic              eot_reg, eot_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    result_t           out_item_reg, out_item_next;

    // Buffer RAM ports.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CODE_W-1:0] rd_data;

    logic              space;
    logic              accept;
    logic              simple_valid;
    result_t           simple_item;
    logic              start_flush;
    logic [CODE_W-1:0] c;
    logic [CODE_W-1:0] lc;
    logic              eot;
    logic              body_last;
    logic              seq_last;
    result_t           seq_item;
    logic [NUM_W+3:0]  num_prod;

    hed_ram #(
        .WIDTH (CODE_W),
        .DEPTH (ENTITY_MAX)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (c),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    // The output register frees up when it is empty or being drained.
    assign space  = !out_valid_reg || char_out.ready;
    assign char_in.ready = (phase_reg == PH_IDLE) && space;
    assign accept = char_in.valid && char_in.ready;

    assign c   = char_in.char_code;
    assign eot = char_in.end_of_text;
    assign lc  = lower_ascii(c);
    assign wr_addr = len_reg[IDX_W-1:0];

    // Ten times the value plus the new digit, computed with shifts.
    assign num_prod = ({4'b0, num_reg} << 3) + ({4'b0, num_reg} << 1)
                    + (NUM_W+4)'(c[3:0]);

    // Decode of one accepted character: either a single result, nothing, or
    // a hand-over to the flush sequencer.
    always_comb
    begin
        in_entity_next  = in_entity_reg;
        len_next        = len_reg;
        num_next        = num_reg;
        stopped_next    = stopped_reg;
        hash_next       = hash_reg;
        m_nbsp_next     = m_nbsp_reg;
        m_lt_next       = m_lt_reg;
        m_gt_next       = m_gt_reg;
        m_amp_next      = m_amp_reg;
        wr_en           = 1'b0;
        simple_valid    = 1'b0;
        simple_item     = char_beat(c, 1'b1, eot);
        start_flush     = 1'b0;
        cnt_next        = cnt_reg;
        tail_valid_next = tail_valid_reg;
        tail_char_next  = tail_char_reg;
        eot_next        = eot_reg;

        if (accept)
        begin
            if (in_entity_reg && c == SEMI_CODE)
            begin
                // Close: a numeric value in range, one of the four names,
                // or nothing at all.
                in_entity_next = 1'b0;
                len_next       = '0;
                if (hash_reg && len_reg != '0)
                begin
                    if (num_reg >= NUM_W'(1) && num_reg <= MAX_CODE)
                    begin
                        simple_valid = 1'b1;
                        simple_item  = char_beat(CODE_W'(num_reg), 1'b1, eot);
                    end
                end
                else if (m_nbsp_reg && len_reg == NBSP_LEN)
                begin
                    simple_valid = 1'b1;
                    simple_item  = char_beat(SPACE_CODE, 1'b1, eot);
                end
                else if (m_lt_reg && len_reg == LT_LEN)
                begin
                    simple_valid = 1'b1;
                    simple_item  = char_beat(LT_CODE, 1'b1, eot);
                end
                else if (m_gt_reg && len_reg == GT_LEN)
                begin
                    simple_valid = 1'b1;
                    simple_item  = char_beat(GT_CODE, 1'b1, eot);
                end
                else if (m_amp_reg && len_reg == AMPN_LEN)
                begin
                    simple_valid = 1'b1;
                    simple_item  = char_beat(AMP_CODE, 1'b1, eot);
                end
            end
            else if (in_entity_reg && len_reg >= ENTITY_FULL)
            begin
                // Overlong entity: flush it, then treat the character as
                // ordinary text. An '&' opens a fresh entity, which end of
                // text flushes at once as a lone '&'.
                start_flush     = 1'b1;
                cnt_next        = ENTITY_FULL;
                eot_next        = eot;
                tail_char_next  = c;
                in_entity_next  = 1'b0;
                len_next        = '0;
                tail_valid_next = (c != AMP_CODE) || eot;
                if (c == AMP_CODE && !eot)
                begin
                    in_entity_next = 1'b1;
                    num_next       = '0;
                    stopped_next   = 1'b0;
                    hash_next      = 1'b0;
                    m_nbsp_next    = 1'b1;
                    m_lt_next      = 1'b1;
                    m_gt_next      = 1'b1;
                    m_amp_next     = 1'b1;
                end
            end
            else if (in_entity_reg)
            begin
                // Append to the buffer and update the running matches.
                wr_en    = 1'b1;
                len_next = len_reg + LEN_W'(1);
                if (len_reg == '0)
                begin
                    hash_next = (c == HASH_CODE);
                end
                else if (hash_reg && !stopped_reg)
                begin
                    if (c >= DIGIT_LO && c <= DIGIT_HI)
                    begin
                        if (num_prod > (NUM_W+4)'(MAX_CODE))
                        begin
                            num_next = NUM_SAT;
                        end
                        else
                        begin
                            num_next = num_prod[NUM_W-1:0];
                        end
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                m_nbsp_next = m_nbsp_reg && len_reg < NBSP_LEN
                            && lc == NAME_NBSP[len_reg[NAME_POS_W-1:0]];
                m_lt_next   = m_lt_reg && len_reg < LT_LEN
                            && lc == NAME_LT[len_reg[NAME_POS_W-1:0]];
                m_gt_next   = m_gt_reg && len_reg < GT_LEN
                            && lc == NAME_GT[len_reg[NAME_POS_W-1:0]];
                m_amp_next  = m_amp_reg && len_reg < AMPN_LEN
                            && lc == NAME_AMP[len_reg[NAME_POS_W-1:0]];
                if (eot)
                begin
                    // Unclosed at end of text: everything held goes out as is.
                    start_flush     = 1'b1;
                    cnt_next        = len_reg + LEN_W'(1);
                    eot_next        = 1'b1;
                    tail_valid_next = 1'b0;
                    in_entity_next  = 1'b0;
                    len_next        = '0;
                end
            end
            else if (c == AMP_CODE)
            begin
                if (eot)
                begin
                    simple_valid = 1'b1;
                    simple_item  = char_beat(AMP_CODE, 1'b1, 1'b1);
                end
                else
                begin
                    in_entity_next = 1'b1;
                    len_next       = '0;
                    num_next       = '0;
                    stopped_next   = 1'b0;
                    hash_next      = 1'b0;
                    m_nbsp_next    = 1'b1;
                    m_lt_next      = 1'b1;
                    m_gt_next      = 1'b1;
                    m_amp_next     = 1'b1;
                end
            end
            else
            begin
                simple_valid = 1'b1;
            end

            // End of text with nothing to say still produces one marker beat.
            if (eot && !simple_valid && !start_flush)
            begin
                simple_valid          = 1'b1;
                simple_item.out_char  = '0;
                simple_item.has_char  = 1'b0;
            end
        end
    end

    // Flush sequencer: '&', then the held characters from the RAM, then an
    // optional trailing character. The RAM is addressed with the index of
    // the next beat, so its registered output always matches idx_reg and
    // simply re-reads the same entry while the output is stalled.
    assign body_last = (LEN_W'(idx_reg) + LEN_W'(1)) == cnt_reg;

    always_comb
    begin
        seq_last = 1'b0;
        seq_item = char_beat(AMP_CODE, 1'b0, 1'b0);
        unique case (phase_reg)
            PH_IDLE:
            begin
                seq_last = 1'b0;
            end
            PH_AMP:
            begin
                seq_last = (cnt_reg == '0) && !tail_valid_reg;
                seq_item = char_beat(AMP_CODE, seq_last, seq_last && eot_reg);
            end
            PH_BODY:
            begin
                seq_last = body_last && !tail_valid_reg;
                seq_item = char_beat(rd_data, seq_last, seq_last && eot_reg);
            end
            PH_TAIL:
            begin
                seq_last = 1'b1;
                seq_item = char_beat(tail_char_reg, 1'b1, eot_reg);
            end
            default:
            begin
                seq_last = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                idx_next = '0;
                if (start_flush)
                begin
                    phase_next = PH_AMP;
                end
            end
            PH_AMP:
            begin
                if (space)
                begin
                    idx_next = '0;
                    if (cnt_reg != '0)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (tail_valid_reg)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_BODY:
            begin
                if (space)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (body_last)
                    begin
                        phase_next = tail_valid_reg ? PH_TAIL : PH_IDLE;
                    end
                end
            end
            PH_TAIL:
            begin
                if (space)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Output register: loaded from the decode path or from the sequencer.
    always_comb
    begin
        out_valid_next = out_valid_reg && !char_out.ready;
        out_item_next  = out_item_reg;
        if (phase_reg != PH_IDLE && space)
        begin
            out_valid_next = 1'b1;
            out_item_next  = seq_item;
        end
        else if (simple_valid)
        begin
            out_valid_next = 1'b1;
            out_item_next  = simple_item;
        end
    end

    assign char_out.valid       = out_valid_reg;
    assign char_out.out_char    = out_item_reg.out_char;
    assign char_out.has_char    = out_item_reg.has_char;
    assign char_out.text_done   = out_item_reg.text_done;
    assign char_out.last_of_run = out_item_reg.last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_entity_reg  <= 1'b0;
            len_reg        <= '0;
            num_reg        <= '0;
            stopped_reg    <= 1'b0;
            hash_reg       <= 1'b0;
            m_nbsp_reg     <= 1'b0;
            m_lt_reg       <= 1'b0;
            m_gt_reg       <= 1'b0;
            m_amp_reg      <= 1'b0;
            phase_reg      <= PH_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            tail_valid_reg <= 1'b0;
            eot_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_entity_reg  <= in_entity_next;
            len_reg        <= len_next;
            num_reg        <= num_next;
            stopped_reg    <= stopped_next;
            hash_reg       <= hash_next;
            m_nbsp_reg     <= m_nbsp_next;
            m_lt_reg       <= m_lt_next;
            m_gt_reg       <= m_gt_next;
            m_amp_reg      <= m_amp_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            tail_valid_reg <= tail_valid_next;
            eot_reg        <= eot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_char_reg <= tail_char_next;
        out_item_reg  <= out_item_next;
    end

    // The held length never runs past the buffer.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= ENTITY_FULL)
        else $error("entity length beyond buffer depth");

    // The sequencer only walks the buffer when there is something held.
    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> (cnt_reg != '0 && LEN_W'(idx_reg) < cnt_reg))
        else $error("buffer read outside the held characters");

    // Once the final beat of a text leaves, no entity is left open.
    a_done_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (char_out.valid && char_out.ready && char_out.text_done) |-> !in_entity_reg)
        else $error("entity still open after end of text");

    // A flush start leaves the decode path silent for that beat.
    a_flush_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && phase_next == PH_AMP) |-> !simple_valid)
        else $error("flush and direct result on the same character");

endmodule

### tb/tb_html_entity_decoder.sv
// Self-checking testbench for html_entity_decoder: streams text characters into
// the decoder, predicts every result beat and compares each one field by field.
// Depends on hed_pkg, the channel interfaces in hed_if and the decoder itself.
module tb_html_entity_decoder import hed_pkg::*; ();

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 5;
    localparam int IDLE_PCT     = 12;
    // Cycles without a beat on either channel before the run is declared hung.
    localparam int STALL_LIMIT  = 3000;
    // Quiet cycles after the last expected beat, enough to cover a full flush.
    localparam int DRAIN_CYCLES = 40;
    // Length of the deliberate hold-off on the result channel.
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 60;
    localparam int RANDOM_UNTIL = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hed_in_if  char_in_bus ();
    hed_out_if char_out_bus ();

    html_entity_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_in_bus),
        .char_out (char_out_bus)
    );

    always #HALF_PERIOD clk = ~clk;

    // Idling rates of the two sides, in percent of cycles. The tests lower them
    // to zero for a stretch so that back-to-back beats are exercised as well.
    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;

    // A one-cycle pulse from the test sequence asks the receiver to hold off.
    logic hold_start = 1'b0;
    int   hold_left  = 0;

    int chars_sent    = 0;
    int beats_checked = 0;
    int error_count   = 0;

    // Decoder state as the predictor sees it: whether an entity is open, the
    // characters held since the '&', and the running value of a numeric entity.
    bit                ent_open    = 1'b0;
    logic [CODE_W-1:0] ent_chars [ENTITY_MAX];
    int                ent_count   = 0;
    int                num_acc     = 0;
    bit                digits_done = 1'b0;

    // Beats caused by the character being predicted, and every beat still owed
    // by the decoder, oldest first.
    result_t run_beats[$];
    result_t expected_beats[$];

    // Characters of the text being built, sent in one go by send_text.
    logic [CODE_W-1:0] text_chars[$];

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Folds A to Z onto a to z by setting the case bit; nothing else changes.
    function automatic logic [CODE_W-1:0] fold_case(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] r;
        r = c;
        if (c >= UPPER_LO && c <= UPPER_HI)
        begin
            r = c | 16'h0020;
        end
        return r;
    endfunction

    // True when the held characters spell the given name, ignoring ASCII case.
    // The name is packed with its first character in the top word.
    function automatic bit held_name_is(input logic [4*CODE_W-1:0] name, input int len);
        bit same;
        same = (ent_count == len);
        for (int i = 0; i < len && same; i++)
        begin
            if (fold_case(ent_chars[i]) != name[(3-i)*CODE_W +: CODE_W])
            begin
                same = 1'b0;
            end
        end
        return same;
    endfunction

    task automatic push_char(input logic [CODE_W-1:0] c);
        result_t beat;
        beat          = '0;
        beat.out_char = c;
        beat.has_char = 1'b1;
        run_beats.push_back(beat);
    endtask

    // Gives back the '&' and every held character as literal text.
    task automatic flush_held();
        push_char(AMP_CODE);
        for (int i = 0; i < ent_count; i++)
        begin
            push_char(ent_chars[i]);
        end
        ent_open  = 1'b0;
        ent_count = 0;
    endtask

    // Works out the beats that one accepted character causes and queues them.
    task automatic decode_char(input logic [CODE_W-1:0] c, input logic eot);
        bit      plain;
        result_t beat;
        plain = 1'b1;
        run_beats.delete();
        if (ent_open)
        begin
            if (c == SEMI_CODE)
            begin
                // The entity closes: a numeric one yields its value when in range,
                // a known name yields its character, anything else is dropped.
                if (ent_count > 0 && ent_chars[0] == HASH_CODE)
                begin
                    if (num_acc >= 1 && num_acc <= int'(MAX_CODE))
                    begin
                        push_char(CODE_W'(num_acc));
                    end
                end
                else if (held_name_is({NAME_NBSP[0], NAME_NBSP[1], NAME_NBSP[2], NAME_NBSP[3]},
                                      int'(NBSP_LEN)))
                begin
                    push_char(SPACE_CODE);
                end
                else if (held_name_is({NAME_LT[0], NAME_LT[1], NAME_LT[2], NAME_LT[3]},
                                      int'(LT_LEN)))
                begin
                    push_char(LT_CODE);
                end
                else if (held_name_is({NAME_GT[0], NAME_GT[1], NAME_GT[2], NAME_GT[3]},
                                      int'(GT_LEN)))
                begin
                    push_char(GT_CODE);
                end
                else if (held_name_is({NAME_AMP[0], NAME_AMP[1], NAME_AMP[2], NAME_AMP[3]},
                                      int'(AMPN_LEN)))
                begin
                    push_char(AMP_CODE);
                end
                ent_open  = 1'b0;
                ent_count = 0;
                plain     = 1'b0;
            end
            else if (ent_count >= ENTITY_MAX)
            begin
                // Over-long entity: give it back, then treat c as plain text.
                flush_held();
            end
            else
            begin
                // Digits count only while they lead the characters after '#';
                // the value saturates just above the largest character code.
                if (ent_count > 0 && ent_chars[0] == HASH_CODE && !digits_done)
                begin
                    if (c >= DIGIT_LO && c <= DIGIT_HI)
                    begin
                        num_acc = num_acc * 10 + int'(c - DIGIT_LO);
                        if (num_acc > int'(MAX_CODE))
                        begin
                            num_acc = int'(NUM_SAT);
                        end
                    end
                    else
                    begin
                        digits_done = 1'b1;
                    end
                end
                ent_chars[ent_count] = c;
                ent_count = ent_count + 1;
                plain = 1'b0;
            end
        end
        if (plain)
        begin
            if (c == AMP_CODE)
            begin
                ent_open    = 1'b1;
                ent_count   = 0;
                num_acc     = 0;
                digits_done = 1'b0;
            end
            else
            begin
                push_char(c);
            end
        end
        // An entity left open when the text ends comes out verbatim.
        if (eot && ent_open)
        begin
            flush_held();
        end
        // A text that ends with nothing to give still closes with an empty beat.
        if (eot && run_beats.size() == 0)
        begin
            beat = '0;
            run_beats.push_back(beat);
        end
        if (run_beats.size() > 0)
        begin
            beat = run_beats.pop_back();
            beat.last_of_run = 1'b1;
            if (eot)
            begin
                beat.text_done = 1'b1;
            end
            run_beats.push_back(beat);
        end
        foreach (run_beats[i])
        begin
            expected_beats.push_back(run_beats[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver and watchdog
    // ------------------------------------------------------------------

    // Counts a failure and says whether it may still be printed, so that a
    // badly broken design cannot flood the log.
    function automatic bit count_error();
        error_count = error_count + 1;
        if (error_count == MAX_REPORTS + 1)
        begin
            $display("%0t: further mismatches are counted but not shown", $time);
        end
        return error_count <= MAX_REPORTS;
    endfunction

    task automatic report_mismatch(input string field, input logic [CODE_W-1:0] want,
                                   input logic [CODE_W-1:0] got);
        if (count_error())
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        end
    endtask

    task automatic check_beat();
        result_t want;
        beats_checked = beats_checked + 1;
        if (expected_beats.size() == 0)
        begin
            if (count_error())
            begin
                $display("%0t: beat with no expectation: expected none, got out_char %h",
                         $time, char_out_bus.out_char);
            end
        end
        else
        begin
            want = expected_beats.pop_front();
            if (char_out_bus.out_char !== want.out_char)
            begin
                report_mismatch("out_char", want.out_char, char_out_bus.out_char);
            end
            if (char_out_bus.has_char !== want.has_char)
            begin
                report_mismatch("has_char", CODE_W'(want.has_char),
                                CODE_W'(char_out_bus.has_char));
            end
            if (char_out_bus.text_done !== want.text_done)
            begin
                report_mismatch("text_done", CODE_W'(want.text_done),
                                CODE_W'(char_out_bus.text_done));
            end
            if (char_out_bus.last_of_run !== want.last_of_run)
            begin
                report_mismatch("last_of_run", CODE_W'(want.last_of_run),
                                CODE_W'(char_out_bus.last_of_run));
            end
        end
    endtask

    // Inputs change only just after a rising edge, so at the falling edge every
    // handshake signal already holds the value that the next rising edge sees.
    always @(negedge clk)
    begin
        if (rst_n && char_out_bus.valid === 1'b1 && char_out_bus.ready === 1'b1)
        begin
            check_beat();
        end
    end

    // The receiver stalls at random, and for a long stretch when asked; the
    // length of that stretch is counted here, independently of the sender.
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            char_out_bus.ready <= 1'b0;
        end
        else
        begin
            char_out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((char_in_bus.valid === 1'b1 && char_in_bus.ready === 1'b1) ||
                (char_out_bus.valid === 1'b1 && char_out_bus.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet = quiet + 1;
            end
        end
        $display("%0t: no beat moved on either channel for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one character, idling at random first, and waits for the beat to
    // be taken. It returns in the time step of the accepting edge, so the next
    // call can keep valid high without lowering it in between.
    task automatic send_char(input logic [CODE_W-1:0] c, input logic eot);
        bit took;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            char_in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_in_bus.valid       <= 1'b1;
        char_in_bus.char_code   <= c;
        char_in_bus.end_of_text <= eot;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = (char_in_bus.ready === 1'b1);
            @(posedge clk);
        end
        decode_char(c, eot);
        chars_sent = chars_sent + 1;
    endtask

    // Sends the characters built up so far, marking the last one as the end of
    // the text when asked.
    task automatic send_text(input bit eot_last);
        for (int i = 0; i < text_chars.size(); i++)
        begin
            send_char(text_chars[i], eot_last && (i == text_chars.size() - 1));
        end
        text_chars.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_chars.push_back(CODE_W'(s[i]));
        end
    endtask

    // Any code at all, printable ASCII, a letter of either case, or a digit.
    function automatic logic [CODE_W-1:0] rand_text_char();
        logic [CODE_W-1:0] c;
        case ($urandom_range(0, 3))
            0:       c = CODE_W'($urandom_range(0, 16'hFFFF));
            1:       c = CODE_W'($urandom_range(16'h0020, 16'h007E));
            2:       c = UPPER_LO + CODE_W'($urandom_range(0, 25))
                         + ($urandom_range(0, 1) ? 16'h0020 : 16'h0000);
            default: c = DIGIT_LO + CODE_W'($urandom_range(0, 9));
        endcase
        return c;
    endfunction

    // A character to hold inside an entity: never ';', sometimes a nested '&'.
    function automatic logic [CODE_W-1:0] rand_entity_char();
        logic [CODE_W-1:0] c;
        c = rand_text_char();
        while (c == SEMI_CODE)
        begin
            c = rand_text_char();
        end
        if ($urandom_range(0, 9) == 0)
        begin
            c = AMP_CODE;
        end
        return c;
    endfunction

    // Appends one random piece of text. Half of the pieces are well-formed entities
    // with random content; the rest are plain text, junk, over-long entities
    // and entities cut off by the end of the text.
    task automatic add_piece(output bit ends_text);
        int                v;
        logic [CODE_W-1:0] c;
        string             word;
        string             digits;
        ends_text = 1'b0;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    text_chars.push_back(rand_text_char());
                end
            end
            2, 3:
            begin
                // A named entity in random case, now and then with a typo.
                case ($urandom_range(0, 3))
                    0:       word = "nbsp";
                    1:       word = "lt";
                    2:       word = "gt";
                    default: word = "amp";
                endcase
                text_chars.push_back(AMP_CODE);
                for (int i = 0; i < word.len(); i++)
                begin
                    c = CODE_W'(word[i]);
                    if ($urandom_range(0, 1))
                    begin
                        c = c - 16'h0020;
                    end
                    if ($urandom_range(0, 15) == 0)
                    begin
                        c = rand_entity_char();
                    end
                    text_chars.push_back(c);
                end
                if ($urandom_range(0, 15) == 0)
                begin
                    text_chars.push_back(rand_entity_char());
                end
                text_chars.push_back(SEMI_CODE);
            end
            4, 5:
            begin
                // A numeric entity, weighted towards the edges of the range.
                case ($urandom_range(0, 7))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = 65535;
                    3:       v = 65536;
                    4:       v = $urandom_range(65537, 999999);
                    5:       v = $urandom_range(1, 255);
                    default: v = $urandom_range(1, 65535);
                endcase
                digits = $sformatf("%0d", v);
                if ($urandom_range(0, 5) == 0)
                begin
                    digits = {"00", digits};
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    digits = "";
                end
                text_chars.push_back(AMP_CODE);
                text_chars.push_back(HASH_CODE);
                add_str(digits);
                // Digits after a non-digit must not count towards the value.
                if ($urandom_range(0, 3) == 0)
                begin
                    text_chars.push_back(CODE_W'($urandom_range(16'h0061, 16'h007A)));
                    text_chars.push_back(DIGIT_LO + CODE_W'($urandom_range(0, 9)));
                end
                text_chars.push_back(SEMI_CODE);
            end
            6:
            begin
                text_chars.push_back(AMP_CODE);
                repeat ($urandom_range(0, ENTITY_MAX))
                begin
                    text_chars.push_back(rand_entity_char());
                end
                text_chars.push_back(SEMI_CODE);
            end
            7:
            begin
                // Fills the buffer and runs past it, forcing a verbatim flush.
                text_chars.push_back(AMP_CODE);
                repeat (ENTITY_MAX + $urandom_range(1, 3))
                begin
                    text_chars.push_back(rand_entity_char());
                end
                if ($urandom_range(0, 1))
                begin
                    text_chars.push_back(SEMI_CODE);
                end
            end
            8:
            begin
                text_chars.push_back(AMP_CODE);
                repeat ($urandom_range(0, 5))
                begin
                    text_chars.push_back(rand_entity_char());
                end
                ends_text = 1'b1;
            end
            default:
            begin
                text_chars.push_back($urandom_range(0, 1) ? SEMI_CODE : HASH_CODE);
            end
        endcase
    endtask

    task automatic send_random_text();
        bit ends_text;
        int pieces;
        ends_text = 1'b0;
        pieces    = $urandom_range(1, 6);
        for (int p = 0; p < pieces && !ends_text; p++)
        begin
            add_piece(ends_text);
        end
        send_text(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The extreme codes pass straight through; the text ends on the last one.
    task automatic test_passthrough();
        text_chars.push_back(16'h0000);
        text_chars.push_back(16'hFFFF);
        send_text(1'b1);
    endtask

    // Each known name once, in mixed case.
    task automatic test_named_entities();
        add_str("&LT;&gt;&Amp;&nBsP;");
        send_text(1'b0);
    endtask

    // A '#' with no digits is dropped; digits stop at the first non-digit.
    task automatic test_numeric_entities();
        add_str("&#;&#9x1;");
        send_text(1'b0);
    endtask

    // An empty entity closing the text leaves only the empty end beat; an
    // entity still open at the end, with an '&' held inside, comes out verbatim.
    task automatic test_end_of_text();
        add_str("&;");
        send_text(1'b1);
        add_str("&a&");
        send_text(1'b1);
    endtask

    task automatic test_random_texts();
        while (chars_sent < RANDOM_UNTIL)
        begin
            send_random_text();
        end
    endtask

    task automatic test_no_idle_stretch();
        int start;
        start = chars_sent;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (chars_sent < start + 80)
        begin
            send_random_text();
        end
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    // The receiver holds off for a long stretch while texts full of verbatim
    // flushes keep coming, so the decoder fills up and stalls its input.
    task automatic test_output_backpressure();
        int start;
        start = chars_sent;
        char_in_bus.valid <= 1'b0;
        hold_start        <= 1'b1;
        @(posedge clk);
        hold_start        <= 1'b0;
        while (chars_sent < start + 60)
        begin
            text_chars.push_back(AMP_CODE);
            repeat (ENTITY_MAX + 1)
            begin
                text_chars.push_back(rand_entity_char());
            end
            send_text(1'b1);
        end
    endtask

    initial
    begin
        char_in_bus.valid       = 1'b0;
        char_in_bus.char_code   = '0;
        char_in_bus.end_of_text = 1'b0;
        char_out_bus.ready      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_named_entities();
        test_numeric_entities();
        test_end_of_text();
        test_random_texts();
        test_no_idle_stretch();
        test_output_backpressure();

        char_in_bus.valid <= 1'b0;
        // A beat still owed and never delivered ends the run via the watchdog.
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters and checked %0d result beats: plain text, named,",
                 chars_sent, beats_checked);
        $display("numeric, empty, over-long and unterminated entities, with stalls on both sides.");
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### html_entity_decoder.f
design/hed_pkg.sv
design/hed_if.sv
design/hed_ram.sv
design/html_entity_decoder.sv
tb/tb_html_entity_decoder.sv
